/* rtl/lkv_pkg.sv */
package lkv_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] req_key;
    logic signed [DATA_W-1:0] req_value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                     go;
    logic                     hit;
    logic                     evict;
    logic signed [DATA_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

endpackage

/* rtl/lru_key_value_cache_unit.sv */
// LRU key/value cache, fully associative, kept as a recency-ordered chain.
// Requests arrive on req (req_valid/req_ready): a get or a put with a
// signed 32-bit key and value. Each request yields one response on rsp
// (rsp_valid/rsp_ready): hit, and the stored value on a get hit, -1 on a
// get miss, 0 on a put.
// Cell 0 holds the most recent entry. A request is registered at accept,
// then, once the response register is free, every cell compares its key and the chain shifts
// by one cell up to the hit position (or through the valid run on a put
// miss) while the new head is loaded into cell 0 and the response is
// registered. A get miss leaves the chain untouched.
// The response is registered in the same cycle as the chain update; a new
// request is accepted only after that update, so one request is handled at a time.
// If rsp is stalled, the update waits until the response register is free;
// req_ready stays low meanwhile.
// cfg_we/cfg_wdata write the capacity (0 acts as 1, above ENTRIES acts as
// ENTRIES); write only while idle. Reset empties the cache, sets capacity
// to 16, and takes effect immediately with no clearing pass.
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  lkv_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output lkv_pkg::rsp_t                rsp,
  input  logic                         cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]    cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  lkv_pkg::state_t               state, state_next;
  lkv_pkg::req_t                 req_q;
  logic [lkv_pkg::CAP_W-1:0]     capacity;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              eff_cap;
  logic                          go;
  logic                          update;
  logic                          hit;
  logic                          evict;
  logic signed [lkv_pkg::DATA_W-1:0] sel_value;
  lkv_pkg::cell_ctl_t            ctl;
  lkv_pkg::entry_t               head;
  lkv_pkg::entry_t               entries [ENTRIES];
  logic [ENTRIES-1:0]            match;
  logic [ENTRIES-1:0]            valid_vec;
  logic [ENTRIES:0]              seen;

  assign req_ready = (state == lkv_pkg::ST_IDLE);
  assign go        = (state == lkv_pkg::ST_BUSY) && (!rsp_valid || rsp_ready);
  assign update    = go && (hit || (req_q.req_type == lkv_pkg::REQ_PUT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lkv_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = lkv_pkg::ST_BUSY;
        end
      end
      lkv_pkg::ST_BUSY: begin
        if (go) begin
          state_next = lkv_pkg::ST_IDLE;
        end
      end
      default: state_next = lkv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign hit   = |match;
  assign evict = (count >= eff_cap);

  always_comb begin
    sel_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        sel_value = sel_value | entries[i].value;
      end
    end
  end

  always_comb begin
    ctl.go    = update;
    ctl.hit   = hit;
    ctl.evict = evict;
    ctl.key   = req_q.req_key;
    head.valid = 1'b1;
    head.key   = req_q.req_key;
    head.value = (hit && req_q.req_type == lkv_pkg::REQ_GET) ? sel_value : req_q.req_value;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .upstream ((g == 0) ? head : entries[(g == 0) ? 0 : g - 1]),
      .seen_in  (seen[g]),
      .entry    (entries[g]),
      .match    (match[g]),
      .seen_out (seen[g+1])
    );
    assign valid_vec[g] = entries[g].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (update && !hit && !evict) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.hit <= hit;
      if (req_q.req_type == lkv_pkg::REQ_PUT) begin
        rsp.read_value <= lkv_pkg::PUT_VALUE;
      end else if (hit) begin
        rsp.read_value <= sel_value;
      end else begin
        rsp.read_value <= lkv_pkg::MISS_VALUE;
      end
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count disagrees with valid cells");

  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot0(valid_vec + ENTRIES'(1)) || (valid_vec == '1))
    else $error("valid cells are not a contiguous run from cell 0");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    (state == lkv_pkg::ST_BUSY) |-> $onehot0(match))
    else $error("key present in more than one cell");

  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == lkv_pkg::ST_BUSY))
    else $error("response raised without an update cycle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= ENTRIES)
    else $error("entry count beyond cell count");

endmodule

/* rtl/lkv_cell.sv */
module lkv_cell (
  input  logic              clk,
  input  logic              rst,
  input  lkv_pkg::cell_ctl_t ctl,
  input  lkv_pkg::entry_t   upstream,
  input  logic              seen_in,
  output lkv_pkg::entry_t   entry,
  output logic              match,
  output logic              seen_out
);

  logic shift;

  assign match    = entry.valid && (entry.key == ctl.key);
  assign seen_out = seen_in | match;

  // hit: cells up to the matching one move down; miss: the valid run moves
  // down, one cell shorter when the tail entry is dropped
  always_comb begin
    if (ctl.hit) begin
      shift = ctl.go & ~seen_in;
    end else if (ctl.evict) begin
      shift = ctl.go & entry.valid;
    end else begin
      shift = ctl.go & upstream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= upstream.valid;
    end
    if (shift) begin
      entry.key   <= upstream.key;
      entry.value <= upstream.value;
    end
  end

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = lkv_pkg::DEFAULT_ENTRIES;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [lkv_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [lkv_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  // Mirror of the cache contents plus the queue of responses still owed.
  class cache_mirror;
    logic signed [lkv_pkg::DATA_W-1:0] stored_key [ENTRIES];
    logic signed [lkv_pkg::DATA_W-1:0] stored_value [ENTRIES];
    bit used [ENTRIES];
    int age [ENTRIES];
    int used_count;
    int capacity;
    lkv_pkg::rsp_t pending_rsp [$];
    int errors, gets, puts, hits, evictions;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 1'b0;
        age[i] = 0;
      end
      used_count = 0;
      capacity = lkv_pkg::CAP_RESET;
      errors = 0;
      gets = 0;
      puts = 0;
      hits = 0;
      evictions = 0;
    endfunction

    // entries more recent than slot age by one, slot becomes most recent
    function void promote(int slot);
      for (int i = 0; i < ENTRIES; i++) begin
        if (used[i] && i != slot && age[i] < age[slot]) age[i]++;
      end
      age[slot] = 0;
    endfunction

    function void note_request(lkv_pkg::req_t r);
      int slot, victim, limit;
      lkv_pkg::rsp_t want;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && used[i] && stored_key[i] == r.req_key) slot = i;
      end
      want.hit = (slot >= 0);
      want.read_value = lkv_pkg::PUT_VALUE;
      if (want.hit) hits++;
      if (r.req_type == lkv_pkg::REQ_GET) begin
        gets++;
        if (slot >= 0) begin
          promote(slot);
          want.read_value = stored_value[slot];
        end else begin
          want.read_value = lkv_pkg::MISS_VALUE;
        end
      end else begin
        puts++;
        if (slot >= 0) begin
          promote(slot);
          stored_value[slot] = r.req_value;
        end else begin
          limit = (capacity < 1) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
          if (used_count >= limit) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (used[i] && (victim < 0 || age[i] > age[victim])) victim = i;
            end
            promote(victim);
            stored_key[victim] = r.req_key;
            stored_value[victim] = r.req_value;
            evictions++;
          end else begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot < 0 && !used[i]) slot = i;
            end
            for (int i = 0; i < ENTRIES; i++) begin
              if (used[i]) age[i]++;
            end
            used[slot] = 1'b1;
            age[slot] = 0;
            stored_key[slot] = r.req_key;
            stored_value[slot] = r.req_value;
            used_count++;
          end
        end
      end
      pending_rsp = {pending_rsp, want};
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_response(lkv_pkg::rsp_t got);
      lkv_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("response with no request pending (hit=%0b value=%0d)",
                                  got.hit, got.read_value));
      end else begin
        want = pending_rsp[0];
        pending_rsp.delete(0);
        if (got.hit !== want.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value %0d, expected %0d",
                                    got.read_value, want.read_value));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  lkv_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  lkv_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [lkv_pkg::CAP_W-1:0] cfg_wdata = '0;

  cache_mirror sb;
  bit steady = 1'b0;
  int stalled = 0;
  int cap_writes = 0;

  lru_key_value_cache_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
    rsp_ready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic issue(logic kind, logic signed [lkv_pkg::DATA_W-1:0] key,
                       logic signed [lkv_pkg::DATA_W-1:0] value);
    lkv_pkg::req_t r;
    r.req_type = kind;
    r.req_key = key;
    r.req_value = value;
    while (!steady && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = cap;
    cap_writes++;
  endtask

  // mostly keys from a small pool so hits, updates and evictions all happen
  task automatic run_random(int n_items, int pool_size);
    logic signed [lkv_pkg::DATA_W-1:0] pool [64];
    logic signed [lkv_pkg::DATA_W-1:0] key;
    for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
    if (pool_size > 2) begin
      pool[0] = KEY_MIN;
      pool[1] = KEY_MAX;
    end
    repeat (n_items) begin
      key = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_size - 1)] : $urandom;
      issue($urandom_range(1) ? lkv_pkg::REQ_PUT : lkv_pkg::REQ_GET, key, $urandom);
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty cache, key and value extremes, update of a present key
    issue(lkv_pkg::REQ_GET, 0, KEY_MAX);
    issue(lkv_pkg::REQ_PUT, KEY_MIN, KEY_MAX);
    issue(lkv_pkg::REQ_PUT, KEY_MAX, KEY_MIN);
    issue(lkv_pkg::REQ_PUT, -1, -1);
    issue(lkv_pkg::REQ_PUT, 0, 0);
    issue(lkv_pkg::REQ_GET, KEY_MIN, $urandom);
    issue(lkv_pkg::REQ_GET, KEY_MAX, $urandom);
    issue(lkv_pkg::REQ_GET, -1, $urandom);
    issue(lkv_pkg::REQ_GET, 0, $urandom);
    issue(lkv_pkg::REQ_GET, 1, $urandom);
    issue(lkv_pkg::REQ_PUT, -1, 32'sh5a5a_a5a5);
    issue(lkv_pkg::REQ_GET, -1, $urandom);
    issue(lkv_pkg::REQ_GET, KEY_MIN, $urandom);

    // capacity dropped below the count, then zero (acts as one)
    set_capacity(2);
    issue(lkv_pkg::REQ_PUT, 7, 70);
    issue(lkv_pkg::REQ_GET, KEY_MAX, $urandom);
    issue(lkv_pkg::REQ_GET, 0, $urandom);
    issue(lkv_pkg::REQ_GET, 7, $urandom);
    set_capacity(0);
    issue(lkv_pkg::REQ_PUT, 8, 80);
    issue(lkv_pkg::REQ_GET, 7, $urandom);
    issue(lkv_pkg::REQ_GET, 8, $urandom);

    set_capacity(31);
    run_random(150, 24);
    set_capacity(3);
    run_random(100, 8);
    set_capacity(1);
    run_random(60, 3);
    steady = 1'b1;
    set_capacity(16);
    run_random(200, 30);
    steady = 1'b0;
    set_capacity(17);
    run_random(60, 20);
    set_capacity(7);
    run_random(150, 12);

    drain();
    $display("Ran %0d requests (%0d gets, %0d puts): %0d hits, %0d evictions",
             sb.gets + sb.puts, sb.gets, sb.puts, sb.hits, sb.evictions);
    $display("Capacity written %0d times, including 0, 1, 16 and 31", cap_writes);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_unit.sv
test/testbench.sv
